@@ design/xepr_pkg.sv @@
// ----------------------------------------------------------------------------
// xepr_pkg: shared types and constants for the XYZ Euler point rotator
// Widths, register codes, coefficient bundles and the sine series reciprocals.
// ----------------------------------------------------------------------------
package xepr_pkg;

  localparam int COORD_BITS     = 24;
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  // sine/cosine span -1.0..+1.0 inclusive: sign plus one integer bit
  localparam int TW = TRIG_FRAC_BITS + 2;
  // intermediate coordinates grow by at most a factor of about five
  localparam int CW = COORD_BITS + 3;
  localparam int PW = CW + TW;

  localparam int NUM_REGS  = 3;
  localparam int REG_IDX_W = 2;
  localparam int CFG_AW    = REG_IDX_W + 2;
  localparam int CFG_DW    = 32;

  localparam int NUM_CELLS   = 3;
  localparam int CELL_STAGES = 2;
  localparam int LATENCY     = NUM_CELLS * CELL_STAGES + 1;

  localparam int             NUM_TERMS = 5;
  localparam int             QUARTER   = 16384;
  localparam logic [31:0]    PI_Q30    = 32'hC90F_DAA2;
  localparam logic [31:0]    ONE_Q30   = 32'h4000_0000;
  localparam logic signed [TW-1:0] COEF_ONE = TW'(longint'(1) << TRIG_FRAC_BITS);

  localparam longint SAT_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    TR_IDLE,
    TR_MUL_X,
    TR_X,
    TR_MUL_X2,
    TR_X2,
    TR_MUL_T,
    TR_DIV,
    TR_T,
    TR_MUL_S,
    TR_S
  } trig_st_t;

  typedef struct packed {
    logic signed [TW-1:0] cos_v;
    logic signed [TW-1:0] sin_v;
  } coef_t;

  typedef struct packed {
    logic     valid;
    reg_idx_t axis;
    coef_t    coef;
  } coef_wr_t;

  typedef struct packed {
    logic                  valid;
    reg_idx_t              axis;
    logic [ANGLE_BITS-1:0] angle;
  } trig_req_t;

  // a, b: the pair rotated by a cell; p: the coordinate passed along
  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] p;
  } pt_t;

  // divisors of the nested sine series, innermost term first (110, 72, 42,
  // 20, 6), as reciprocals: floor(n / d) is (n * recip) >> shift for any
  // 32-bit n
  function automatic logic [32:0] series_recip(logic [2:0] step);
    logic [32:0] m;
    case (step)
      3'd0:    m = 33'd4997780127;
      3'd1:    m = 33'd7635497416;
      3'd2:    m = 33'd6544712071;
      3'd3:    m = 33'd6871947674;
      default: m = 33'd5726623062;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] series_shift(logic [2:0] step);
    logic [5:0] s;
    case (step)
      3'd0:    s = 6'd39;
      3'd1:    s = 6'd39;
      3'd2:    s = 6'd38;
      3'd3:    s = 6'd37;
      default: s = 6'd35;
    endcase
    return s;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(logic signed [CW-1:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v > CW'(SAT_HI)) begin
      r = COORD_BITS'(SAT_HI);
    end else if (v < CW'(SAT_LO)) begin
      r = COORD_BITS'(SAT_LO);
    end else begin
      r = COORD_BITS'(v);
    end
    return r;
  endfunction

endpackage

@@ design/xepr_trig.sv @@
// ----------------------------------------------------------------------------
// xepr_trig: sine/cosine generator for one rotation angle
// One shared 32x33 multiplier evaluates the first-quadrant sine series twice
// per angle, dividing by reciprocal multiplication, then folds into quadrants.
// ----------------------------------------------------------------------------
module xepr_trig
  import xepr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  trig_req_t req,
  output logic      busy,
  output coef_wr_t  wr
);

  localparam logic [32:0] ROUND_ADD = 33'(1) << (29 - TRIG_FRAC_BITS);

  trig_st_t st_r, st_nxt;

  reg_idx_t                axis_r,  axis_nxt;
  logic [1:0]              quad_r,  quad_nxt;
  logic [13:0]             rem14_r, rem14_nxt;
  logic [14:0]             u_r,     u_nxt;
  logic                    pass_r,  pass_nxt;
  logic [31:0]             x_r,     x_nxt;
  logic [31:0]             x2_r,    x2_nxt;
  logic [30:0]             t_r,     t_nxt;
  logic [2:0]              step_r,  step_nxt;
  logic [64:0]             prod_r,  prod_nxt;
  logic [31:0]             dq_r,    dq_nxt;
  logic [TRIG_FRAC_BITS:0] mag0_r,  mag0_nxt;

  logic [31:0]             mul_a;
  logic [32:0]             mul_b;
  logic [15:0]             phase;
  logic [31:0]             quot;
  logic [32:0]             rnd_sum;
  logic [TRIG_FRAC_BITS:0] mag_now;
  logic [TRIG_FRAC_BITS:0] sin_mag;
  logic [TRIG_FRAC_BITS:0] cos_mag;

  assign phase   = 16'(req.angle) << (16 - ANGLE_BITS);
  assign quot    = 32'(prod_r >> series_shift(step_r));
  assign rnd_sum = {1'b0, prod_r[61:30]} + ROUND_ADD;
  assign mag_now = (TRIG_FRAC_BITS + 1)'(rnd_sum >> (30 - TRIG_FRAC_BITS));
  assign sin_mag = quad_r[0] ? mag_now : mag0_r;
  assign cos_mag = quad_r[0] ? mag0_r : mag_now;
  assign busy    = (st_r != TR_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    axis_nxt  = axis_r;
    quad_nxt  = quad_r;
    rem14_nxt = rem14_r;
    u_nxt     = u_r;
    pass_nxt  = pass_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    t_nxt     = t_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    dq_nxt    = dq_r;
    mag0_nxt  = mag0_r;
    mul_a     = '0;
    mul_b     = '0;
    wr        = '0;
    case (st_r)
      TR_IDLE: begin
        if (req.valid) begin
          axis_nxt  = req.axis;
          quad_nxt  = phase[15:14];
          rem14_nxt = phase[13:0];
          u_nxt     = {1'b0, phase[13:0]};
          pass_nxt  = 1'b0;
          st_nxt    = TR_MUL_X;
        end
      end
      TR_MUL_X: begin
        mul_a    = 32'(u_r);
        mul_b    = {1'b0, PI_Q30};
        prod_nxt = mul_a * mul_b;
        st_nxt   = TR_X;
      end
      TR_X: begin
        x_nxt  = 32'((prod_r + 65'd16384) >> 15);
        st_nxt = TR_MUL_X2;
      end
      TR_MUL_X2: begin
        mul_a    = x_r;
        mul_b    = {1'b0, x_r};
        prod_nxt = mul_a * mul_b;
        st_nxt   = TR_X2;
      end
      TR_X2: begin
        x2_nxt   = prod_r[61:30];
        t_nxt    = 31'(ONE_Q30);
        step_nxt = '0;
        st_nxt   = TR_MUL_T;
      end
      TR_MUL_T: begin
        // hold the scaled product as the dividend for the next cycle
        mul_a    = x2_r;
        mul_b    = {2'b0, t_r};
        prod_nxt = mul_a * mul_b;
        dq_nxt   = prod_nxt[61:30];
        st_nxt   = TR_DIV;
      end
      TR_DIV: begin
        mul_a    = dq_r;
        mul_b    = series_recip(step_r);
        prod_nxt = mul_a * mul_b;
        st_nxt   = TR_T;
      end
      TR_T: begin
        t_nxt = 31'(ONE_Q30 - quot);
        if (step_r == 3'(NUM_TERMS - 1)) begin
          st_nxt = TR_MUL_S;
        end else begin
          step_nxt = step_r + 3'd1;
          st_nxt   = TR_MUL_T;
        end
      end
      TR_MUL_S: begin
        mul_a    = x_r;
        mul_b    = {2'b0, t_r};
        prod_nxt = mul_a * mul_b;
        st_nxt   = TR_S;
      end
      TR_S: begin
        if (!pass_r) begin
          // hold the sine of the remainder, go again for its complement
          mag0_nxt = mag_now;
          pass_nxt = 1'b1;
          u_nxt    = 15'(QUARTER) - {1'b0, rem14_r};
          st_nxt   = TR_MUL_X;
        end else begin
          wr.valid      = 1'b1;
          wr.axis       = axis_r;
          wr.coef.sin_v = quad_r[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
          wr.coef.cos_v = (quad_r[1] ^ quad_r[0]) ? -$signed({1'b0, cos_mag})
                                                  :  $signed({1'b0, cos_mag});
          st_nxt        = TR_IDLE;
        end
      end
      default: begin
        st_nxt = TR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    axis_r  <= axis_nxt;
    quad_r  <= quad_nxt;
    rem14_r <= rem14_nxt;
    u_r     <= u_nxt;
    pass_r  <= pass_nxt;
    x_r     <= x_nxt;
    x2_r    <= x2_nxt;
    t_r     <= t_nxt;
    step_r  <= step_nxt;
    prod_r  <= prod_nxt;
    dq_r    <= dq_nxt;
    mag0_r  <= mag0_nxt;
  end

endmodule

@@ design/xepr_cell.sv @@
// ----------------------------------------------------------------------------
// xepr_cell: one axis rotation cell
// Holds its axis's cosine and sine, rotates the (a, b) pair in two stages
// and hands the point on, reordered for the next axis.
// ----------------------------------------------------------------------------
module xepr_cell
  import xepr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  coef_we,
  input  coef_t coef_in,
  input  pt_t   pt_in,
  output pt_t   pt_out
);

  localparam logic signed [PW:0] RND_HALF = (PW + 1)'(1) << (TRIG_FRAC_BITS - 1);

  logic signed [TW-1:0] cos_r;
  logic signed [TW-1:0] sin_r;

  logic                 v1_r;
  logic signed [PW-1:0] ac_r, ac_nxt;
  logic signed [PW-1:0] bs_r, bs_nxt;
  logic signed [PW-1:0] as_r, as_nxt;
  logic signed [PW-1:0] bc_r, bc_nxt;
  logic signed [CW-1:0] p1_r;

  logic                 v2_r;
  logic signed [PW:0]   dif;
  logic signed [PW:0]   sum;
  logic signed [CW-1:0] a2_r, a2_nxt;
  logic signed [CW-1:0] b2_r, b2_nxt;
  logic signed [CW-1:0] p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= COEF_ONE;
      sin_r <= '0;
    end else if (coef_we) begin
      cos_r <= coef_in.cos_v;
      sin_r <= coef_in.sin_v;
    end
  end

  assign ac_nxt = $signed(pt_in.a) * cos_r;
  assign bs_nxt = $signed(pt_in.b) * sin_r;
  assign as_nxt = $signed(pt_in.a) * sin_r;
  assign bc_nxt = $signed(pt_in.b) * cos_r;

  // round half up: add half an lsb, then floor
  assign dif    = ac_r - bs_r + RND_HALF;
  assign sum    = as_r + bc_r + RND_HALF;
  assign a2_nxt = CW'(dif >>> TRIG_FRAC_BITS);
  assign b2_nxt = CW'(sum >>> TRIG_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= pt_in.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ac_r <= ac_nxt;
    bs_r <= bs_nxt;
    as_r <= as_nxt;
    bc_r <= bc_nxt;
    p1_r <= pt_in.p;
    a2_r <= a2_nxt;
    b2_r <= b2_nxt;
    p2_r <= p1_r;
  end

  // next axis rotates (b', p) and carries a'
  assign pt_out.valid = v2_r;
  assign pt_out.a     = b2_r;
  assign pt_out.b     = p2_r;
  assign pt_out.p     = a2_r;

endmodule

@@ design/xyz_euler_point_rotation.sv @@
// ----------------------------------------------------------------------------
// xyz_euler_point_rotation: rotate 3D points about X, then Y, then Z
// Row of three rotation cells with a coefficient generator and APB registers.
// ----------------------------------------------------------------------------
// Usage
//   Registers 0..2 (byte addresses 0, 4, 8) hold the X, Y and Z angles in
//   units of a full turn over 65536. A write marks that axis for a recompute
//   of its cosine and sine: busy stays high from the access cycle while the
//   angle is handed to the generator and two passes of the five-term sine
//   series (each term a product, a reciprocal multiply and a subtract) run
//   through one shared multiplier. Writes that land while busy mark their
//   axes pending, and the generator takes them lowest axis first.
//   A point is taken at each rising edge with start high and busy low, one
//   per cycle with no gaps needed. The rotated, saturated point appears on
//   out_x/out_y/out_z with out_valid after two stages per axis cell and the
//   output register, and lasts one cycle; the receiver cannot stall, so
//   every transaction simply flows out. Reset clears the angles to zero,
//   sets the coefficients to the identity rotation and clears all valid
//   flags; points in flight are dropped.
// ----------------------------------------------------------------------------
module xyz_euler_point_rotation
  import xepr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_AW-1:0]            paddr,
  input  logic [CFG_DW-1:0]            pwdata,
  output logic [CFG_DW-1:0]            prdata,
  output logic                         pready
);

  logic [ANGLE_BITS-1:0] ang_x_r;
  logic [ANGLE_BITS-1:0] ang_y_r;
  logic [ANGLE_BITS-1:0] ang_z_r;

  logic [NUM_REGS-1:0]   pend_r, pend_nxt;

  logic      cfg_wr;
  reg_idx_t  cfg_idx;
  trig_req_t treq;
  coef_wr_t  cwr;
  logic      trig_busy;
  pt_t       chain [NUM_CELLS+1];

  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r;
  logic signed [COORD_BITS-1:0] out_y_r;
  logic signed [COORD_BITS-1:0] out_z_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_comb begin
    pend_nxt   = pend_r;
    treq.valid = 1'b0;
    treq.axis  = REG_ANGLE_X;
    treq.angle = ang_x_r;
    // issue the lowest pending axis once the generator is free
    if (!trig_busy) begin
      if (pend_r[REG_ANGLE_X]) begin
        treq.valid            = 1'b1;
        pend_nxt[REG_ANGLE_X] = 1'b0;
      end else if (pend_r[REG_ANGLE_Y]) begin
        treq.valid            = 1'b1;
        treq.axis             = REG_ANGLE_Y;
        treq.angle            = ang_y_r;
        pend_nxt[REG_ANGLE_Y] = 1'b0;
      end else if (pend_r[REG_ANGLE_Z]) begin
        treq.valid            = 1'b1;
        treq.axis             = REG_ANGLE_Z;
        treq.angle            = ang_z_r;
        pend_nxt[REG_ANGLE_Z] = 1'b0;
      end
    end
    // a write re-arms its axis, even one being issued in the same cycle
    if (cfg_wr) begin
      case (cfg_idx)
        REG_ANGLE_X: pend_nxt[REG_ANGLE_X] = 1'b1;
        REG_ANGLE_Y: pend_nxt[REG_ANGLE_Y] = 1'b1;
        REG_ANGLE_Z: pend_nxt[REG_ANGLE_Z] = 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_x_r <= '0;
      ang_y_r <= '0;
      ang_z_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ANGLE_X: ang_x_r <= pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_Y: ang_y_r <= pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_Z: ang_z_r <= pwdata[ANGLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ANGLE_X: prdata = CFG_DW'(ang_x_r);
      REG_ANGLE_Y: prdata = CFG_DW'(ang_y_r);
      REG_ANGLE_Z: prdata = CFG_DW'(ang_z_r);
      default:     prdata = '0;
    endcase
  end

  xepr_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (treq),
    .busy  (trig_busy),
    .wr    (cwr)
  );

  // hold off points in the write cycle too, so no point sees stale terms
  assign busy = trig_busy | cfg_wr | (|pend_r);

  assign chain[0].valid = start & ~busy;
  assign chain[0].a     = CW'(in_y);
  assign chain[0].b     = CW'(in_z);
  assign chain[0].p     = CW'(in_x);

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    xepr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .coef_we (cwr.valid && (cwr.axis == reg_idx_t'(REG_IDX_W'(g)))),
      .coef_in (cwr.coef),
      .pt_in   (chain[g]),
      .pt_out  (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[NUM_CELLS].valid;
    end
  end

  // after the Z cell: a = y3, b = z2, p = x3
  always_ff @(posedge clk) begin
    out_x_r <= sat_coord(chain[NUM_CELLS].p);
    out_y_r <= sat_coord(chain[NUM_CELLS].a);
    out_z_r <= sat_coord(chain[NUM_CELLS].b);
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

endmodule

@@ design/xepr_chk.sv @@
// ----------------------------------------------------------------------------
// xepr_chk: port-level checks for the XYZ Euler point rotator
// Latency of the point pipeline and coupling of busy to register writes.
// ----------------------------------------------------------------------------
module xepr_chk
  import xepr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic              pready,
  input logic [CFG_AW-1:0] paddr
);

  // every accepted transaction comes out after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted point did not emerge after pipeline latency");

  // no result without a matching accepted transaction
  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without an accepted point");

  a_busy_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> (psel && penable && pwrite))
    else $error("busy raised without a register write");

  // an angle write must start a coefficient recompute
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready &&
     (paddr[CFG_AW-1:2] < REG_IDX_W'(NUM_REGS))) |=> busy)
    else $error("angle write did not hold off points");

endmodule

bind xyz_euler_point_rotation xepr_chk u_xepr_chk (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the XYZ Euler point rotator
// Points go in through the start/busy handshake and the angles are set over
// APB between phases. A bit-exact predictor of the fixed-point sine series
// and the three axis rotations supplies the expected point for every
// transaction. Each rotated point is checked in order as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  import xepr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int POINT_COUNT  = 1750;
  localparam int QUIET_TAIL   = 200;

  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned Q30_PI  = 64'd3373259426;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  coord_t              in_x;
  coord_t              in_y;
  coord_t              in_z;
  logic                out_valid;
  coord_t              out_x;
  coord_t              out_y;
  coord_t              out_z;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  logic [ANGLE_BITS-1:0] angle_reg [NUM_REGS];
  longint                sin_coef  [NUM_REGS];
  longint                cos_coef  [NUM_REGS];
  point_t                rotated_due [$];
  point_t                head;
  int                    mismatches  = 0;
  int                    cycle_count = 0;
  int                    points_sent = 0;
  logic                  quiet       = 1'b0;

  xyz_euler_point_rotation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // first-quadrant sine in Q2.30, u in 0..16384 (a quarter turn)
  function automatic longint unsigned quarter_sine(longint unsigned u);
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned t;
    ang = (u * Q30_PI + 64'd16384) >> 15;
    sq  = (ang * ang) >> 30;
    t   = Q30_ONE;
    t   = Q30_ONE - (((sq * t) >> 30) / 64'd110);
    t   = Q30_ONE - (((sq * t) >> 30) / 64'd72);
    t   = Q30_ONE - (((sq * t) >> 30) / 64'd42);
    t   = Q30_ONE - (((sq * t) >> 30) / 64'd20);
    t   = Q30_ONE - (((sq * t) >> 30) / 64'd6);
    return (ang * t) >> 30;
  endfunction

  function automatic longint trig_value(logic [15:0] phase);
    longint unsigned s30;
    longint unsigned mag;
    if (phase[14]) begin
      s30 = quarter_sine(64'd16384 - phase[13:0]);
    end else begin
      s30 = quarter_sine(phase[13:0]);
    end
    mag = (s30 + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    return phase[15] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic void set_angle(logic [REG_IDX_W-1:0] idx, logic [ANGLE_BITS-1:0] angle);
    logic [15:0] phase;
    angle_reg[idx] = angle;
    phase = 16'(angle) << (16 - ANGLE_BITS);
    sin_coef[idx] = trig_value(phase);
    cos_coef[idx] = trig_value(phase + 16'd16384);
  endfunction

  // floor((v + half) / 2^F): ties go towards plus infinity
  function automatic longint round_q(longint v);
    return (v + (longint'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_MAX) begin
      return coord_t'(COORD_MAX);
    end
    if (v < COORD_MIN) begin
      return coord_t'(COORD_MIN);
    end
    return coord_t'(v);
  endfunction

  // intermediates stay unsaturated; only the final coordinates clamp
  function automatic point_t rotate_point(coord_t x, coord_t y, coord_t z);
    longint px;
    longint py;
    longint pz;
    longint y1;
    longint z1;
    longint x2;
    longint z2;
    longint x3;
    longint y3;
    point_t r;
    px = x;
    py = y;
    pz = z;
    y1 = round_q(py * cos_coef[REG_ANGLE_X] - pz * sin_coef[REG_ANGLE_X]);
    z1 = round_q(py * sin_coef[REG_ANGLE_X] + pz * cos_coef[REG_ANGLE_X]);
    z2 = round_q(z1 * cos_coef[REG_ANGLE_Y] - px * sin_coef[REG_ANGLE_Y]);
    x2 = round_q(z1 * sin_coef[REG_ANGLE_Y] + px * cos_coef[REG_ANGLE_Y]);
    x3 = round_q(x2 * cos_coef[REG_ANGLE_Z] - y1 * sin_coef[REG_ANGLE_Z]);
    y3 = round_q(x2 * sin_coef[REG_ANGLE_Z] + y1 * cos_coef[REG_ANGLE_Z]);
    r.x = clamp_coord(x3);
    r.y = clamp_coord(y3);
    r.z = clamp_coord(z2);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_value(input string what, input logic signed [63:0] due,
                             input logic signed [63:0] got);
    if (got !== due) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", what, due, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (rotated_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with nothing pending: (%0d, %0d, %0d)", out_x, out_y, out_z);
        end
      end else begin
        head = rotated_due.pop_front();
        check_value("out_x", $signed(head.x), out_x);
        check_value("out_y", $signed(head.y), out_y);
        check_value("out_z", $signed(head.z), out_z);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    in_x  <= x;
    in_y  <= y;
    in_z  <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    rotated_due.push_back(rotate_point(x, y, z));
    points_sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (rotated_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    int k;
    wait_drained();
    while (busy) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx < NUM_REGS) begin
      set_angle(idx, data[ANGLE_BITS-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // the coefficient recompute raises busy shortly after the write; hold
    // until it has been seen and has cleared
    k = 0;
    while (!busy && k < 4) begin
      @(posedge clk);
      k++;
    end
    while (busy) @(posedge clk);
  endtask

  function automatic coord_t extreme_coord();
    coord_t r;
    case ($urandom_range(0, 4))
      0:       r = coord_t'(COORD_MAX);
      1:       r = coord_t'(COORD_MIN);
      2:       r = '0;
      3:       r = -1;
      default: r = 1;
    endcase
    return r;
  endfunction

  function automatic coord_t random_coord();
    coord_t r;
    case ($urandom_range(0, 9))
      7:       r = coord_t'(int'($urandom_range(0, 512)) - 256);
      8, 9:    r = extreme_coord();
      default: r = coord_t'($urandom);
    endcase
    return r;
  endfunction

  // upper bits of the data word are random junk that the block must drop
  function automatic logic [CFG_DW-1:0] random_angle_word();
    logic [CFG_DW-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 11))
      0:       w[15:0] = 16'd0;
      1:       w[15:0] = 16'hFFFF;
      2:       w[15:0] = 16'd16384;
      3:       w[15:0] = 16'd32768;
      4:       w[15:0] = 16'd49152;
      5:       w[15:0] = 16'd8192;
      6:       w[15:0] = 16'd1;
      default: w = w;
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_identity_extremes();
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MIN), 0);
    send_point(coord_t'(COORD_MIN), coord_t'(COORD_MAX), -1);
    send_point(-1, 1, coord_t'(COORD_MAX));
    send_point(24'sh555555, 24'shAAAAAA, coord_t'(COORD_MIN));
    send_point(24'shAAAAAA, 24'sh555555, 24'sh7FFFFF);
  endtask

  task automatic test_register_access();
    int r;
    cfg_write(REG_ANGLE_X, 32'hFFFF_2000);
    cfg_write(REG_ANGLE_Y, 32'hABCD_0000);
    cfg_write(REG_ANGLE_Z, 32'h0001_FFFF);
    cfg_write(REG_UNMAPPED, 32'hDEAD_1234);
    for (r = 0; r < NUM_REGS; r++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {REG_IDX_W'(r), 2'b00};
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      check_value("angle readback", 64'(angle_reg[r]), 64'(prdata));
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    send_point(coord_t'(COORD_MIN), 12345, -54321);
  endtask

  task automatic test_quadrant_angles();
    int s;
    for (s = 0; s < 3; s++) begin
      case (s)
        0: begin
          cfg_write(REG_ANGLE_X, 32'd16384);
          cfg_write(REG_ANGLE_Y, 32'd32768);
          cfg_write(REG_ANGLE_Z, 32'd49152);
        end
        1: begin
          cfg_write(REG_ANGLE_X, 32'd65535);
          cfg_write(REG_ANGLE_Y, 32'd65535);
          cfg_write(REG_ANGLE_Z, 32'd65535);
        end
        default: begin
          cfg_write(REG_ANGLE_X, 32'd32768);
          cfg_write(REG_ANGLE_Y, 32'd0);
          cfg_write(REG_ANGLE_Z, 32'd16384);
        end
      endcase
      send_point(coord_t'(COORD_MAX), coord_t'(COORD_MIN), 1);
      send_point(coord_t'(COORD_MIN), coord_t'(COORD_MAX), -1);
    end
  endtask

  // with an odd coefficient, an odd multiple of half an LSB lands exactly
  // on a rounding tie; other axes at zero keep the later steps exact
  task automatic test_rounding_ties();
    logic [15:0] a;
    logic        found;
    a = 16'd1;
    found = 1'b0;
    while (!found && a < 16'd16384) begin
      if (trig_value(a) % 2 != 0 && trig_value(a + 16'd16384) % 2 != 0) begin
        found = 1'b1;
      end else begin
        a++;
      end
    end
    cfg_write(REG_ANGLE_X, 32'(a));
    cfg_write(REG_ANGLE_Y, 32'd0);
    cfg_write(REG_ANGLE_Z, 32'd0);
    send_point(0, 16384, 0);
    send_point(0, -16384, 0);
    send_point(0, 0, 16384);
    send_point(7, 3 * 16384, -16384);
  endtask

  // X at 45 degrees pushes z past the coordinate range; Y at 45 degrees
  // folds it back in, so only an unsaturated intermediate gets it right
  task automatic test_intermediate_growth();
    cfg_write(REG_ANGLE_X, 32'd8192);
    cfg_write(REG_ANGLE_Y, 32'd8192);
    cfg_write(REG_ANGLE_Z, 32'd0);
    send_point(0, coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    send_point(0, coord_t'(COORD_MIN), coord_t'(COORD_MIN));
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX));
  endtask

  task automatic test_random_points();
    int phase_len;
    int n;
    int phase_no;
    phase_no = 0;
    while (points_sent < POINT_COUNT) begin
      cfg_write(REG_ANGLE_X, random_angle_word());
      cfg_write(REG_ANGLE_Y, random_angle_word());
      cfg_write(REG_ANGLE_Z, random_angle_word());
      phase_len = $urandom_range(60, 160);
      for (n = 0; n < phase_len && points_sent < POINT_COUNT; n++) begin
        quiet = (points_sent >= POINT_COUNT - QUIET_TAIL);
        // hold the sender until the pipeline has emptied
        if (n == phase_len / 2 && (phase_no == 0 || $urandom_range(0, 3) == 0)) begin
          wait_drained();
        end
        send_point(random_coord(), random_coord(), random_coord());
      end
      phase_no++;
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_x    = '0;
    in_y    = '0;
    in_z    = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    set_angle(REG_ANGLE_X, '0);
    set_angle(REG_ANGLE_Y, '0);
    set_angle(REG_ANGLE_Z, '0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_identity_extremes();
    test_register_access();
    test_quadrant_angles();
    test_rounding_ties();
    test_intermediate_growth();
    test_random_points();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
